// ===== sv/rbd_pkg.sv =====
// shared types and constants for the 2x2 rgb box downscaler
// no dependencies; used by every module of the block
`default_nettype none

package rbd_pkg;

    // frame size limits
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;

    // widths
    localparam int CHAN_W  = 8;
    localparam int SUM_W   = CHAN_W + 1;          // pair sum of one channel
    localparam int TOT_W   = CHAN_W + 2;          // sum of four pixels
    localparam int COL_W   = $clog2(MAX_WIDTH);   // column counter
    localparam int ROW_W   = $clog2(MAX_HEIGHT);  // row counter
    localparam int WID_W   = 12;                  // image_width register
    localparam int HGT_W   = 13;                  // image_height register
    localparam int IDX_W   = $clog2(LINE_DEPTH);  // line buffer address
    localparam int CFG_W   = 13;                  // widest register
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // register reset values
    localparam logic [WID_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd480;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              frame_last;
    } pixel_out_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } pair_sum_t;

    // per-pixel decode from the position tracker
    typedef struct packed {
        logic             load_first;  // even column inside the frame
        logic             store_pair;  // odd column of an even row
        logic             emit;        // odd column of an odd row
        logic             last;        // last block of the frame
        logic [IDX_W-1:0] idx;         // line buffer slot of this pair
    } pos_ctl_t;

endpackage

`default_nettype wire

// ===== sv/rbd_line_buf.sv =====
// line buffer of horizontal pair sums, one write and one registered read port
// depends on rbd_pkg
`default_nettype none

module rbd_line_buf
(
    input  wire logic                    clk,
    input  wire logic                    we,
    input  wire logic [rbd_pkg::IDX_W-1:0] waddr,
    input  var  rbd_pkg::pair_sum_t      wdata,
    input  wire logic                    re,
    input  wire logic [rbd_pkg::IDX_W-1:0] raddr,
    output rbd_pkg::pair_sum_t           rdata
);

    rbd_pkg::pair_sum_t mem [rbd_pkg::LINE_DEPTH];
    rbd_pkg::pair_sum_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/rbd_pos_ctrl.sv =====
// frame size registers, column and row counters and per-pixel decode
// depends on rbd_pkg
`default_nettype none

module rbd_pos_ctrl
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rbd_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic                        accept,
    output rbd_pkg::pos_ctl_t                ctl
);

    localparam logic [rbd_pkg::WID_W-1:0] W_MIN = rbd_pkg::WID_W'(2);
    localparam logic [rbd_pkg::WID_W-1:0] W_MAX = rbd_pkg::WID_W'(rbd_pkg::MAX_WIDTH);
    localparam logic [rbd_pkg::HGT_W-1:0] H_MIN = rbd_pkg::HGT_W'(2);
    localparam logic [rbd_pkg::HGT_W-1:0] H_MAX = rbd_pkg::HGT_W'(rbd_pkg::MAX_HEIGHT);

    logic [rbd_pkg::WID_W-1:0] width_reg;
    logic [rbd_pkg::HGT_W-1:0] height_reg;
    logic [rbd_pkg::WID_W-1:0] width_next;
    logic [rbd_pkg::HGT_W-1:0] height_next;
    logic [rbd_pkg::WID_W-1:0] wr_width;
    logic [rbd_pkg::HGT_W-1:0] wr_height;
    logic [rbd_pkg::COL_W-1:0] col_reg;
    logic [rbd_pkg::ROW_W-1:0] row_reg;
    logic [rbd_pkg::COL_W-1:0] col_next;
    logic [rbd_pkg::ROW_W-1:0] row_next;
    logic [rbd_pkg::WID_W-1:0] col_wide;
    logic [rbd_pkg::HGT_W-1:0] row_wide;
    logic [rbd_pkg::WID_W-1:0] col_inc;
    logic [rbd_pkg::HGT_W-1:0] row_inc;
    logic [rbd_pkg::WID_W-1:0] last_col;
    logic [rbd_pkg::HGT_W-1:0] last_row;
    logic                      in_frame;

    // sizes are clamped once, when written
    always_comb
    begin
        wr_width  = cfg_data[rbd_pkg::WID_W-1:0];
        wr_height = cfg_data[rbd_pkg::HGT_W-1:0];
        if (wr_width < W_MIN)
        begin
            wr_width = W_MIN;
        end
        else if (wr_width > W_MAX)
        begin
            wr_width = W_MAX;
        end
        if (wr_height < H_MIN)
        begin
            wr_height = H_MIN;
        end
        else if (wr_height > H_MAX)
        begin
            wr_height = H_MAX;
        end
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                rbd_pkg::REG_IMAGE_WIDTH:  width_next  = wr_width;
                rbd_pkg::REG_IMAGE_HEIGHT: height_next = wr_height;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        col_wide = rbd_pkg::WID_W'(col_reg);
        row_wide = rbd_pkg::HGT_W'(row_reg);
        col_inc  = col_wide + rbd_pkg::WID_W'(1);
        row_inc  = row_wide + rbd_pkg::HGT_W'(1);
        in_frame = (col_wide < width_reg) && (row_wide < height_reg);
        last_col = {width_reg[rbd_pkg::WID_W-1:1], 1'b0} - rbd_pkg::WID_W'(1);
        last_row = {height_reg[rbd_pkg::HGT_W-1:1], 1'b0} - rbd_pkg::HGT_W'(1);

        // wrap at end of line and end of frame
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_inc >= width_reg)
            begin
                col_next = '0;
                if (row_inc >= height_reg)
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_inc[rbd_pkg::ROW_W-1:0];
                end
            end
            else
            begin
                col_next = col_inc[rbd_pkg::COL_W-1:0];
            end
        end

        ctl.load_first = in_frame && !col_reg[0];
        ctl.store_pair = in_frame && col_reg[0] && !row_reg[0];
        ctl.emit       = in_frame && col_reg[0] && row_reg[0];
        ctl.last       = (col_wide == last_col) && (row_wide == last_row);
        ctl.idx        = col_reg[rbd_pkg::COL_W-1:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rbd_pkg::WIDTH_RESET;
            height_reg <= rbd_pkg::HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rgb_box_downscale_2x2_unit.sv =====
// top level of the 2x2 rgb box downscaler
// depends on rbd_pkg, rbd_line_buf and rbd_pos_ctrl
`default_nettype none

// channel   dir  handshake               payload
// pix       in   pix_valid / pix_ready   rbd_pkg::pixel_in_t, raster order
// res       out  res_valid / res_ready   rbd_pkg::pixel_out_t, one per 2x2 block
// cfg       in   cfg_we (no wait)        cfg_index selects width or height
//
// one pixel transfer per cycle sustained unless a stalled result fills both stages;
// the closing pixel of a block is registered with its line buffer read, then added
// reset clears counters and valid flags and loads 640 x 480; the line buffer
// has no reset and is always written on an even row before it is read
// a stalled result blocks input only when the add stage is also full

module rgb_box_downscale_2x2_unit
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        pix_valid,
    output      logic                        pix_ready,
    input  var  rbd_pkg::pixel_in_t          pix,
    output      logic                        res_valid,
    input  wire logic                        res_ready,
    output rbd_pkg::pixel_out_t              res,
    input  wire logic                        cfg_we,
    input  wire logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rbd_pkg::CFG_W-1:0]   cfg_data
);

    rbd_pkg::pos_ctl_t   ctl;
    rbd_pkg::pair_sum_t  pair_sum;
    rbd_pkg::pair_sum_t  line_rd;
    rbd_pkg::pixel_in_t  first_reg;
    rbd_pkg::pair_sum_t  s1_sum_reg;
    logic                s1_valid_reg;
    logic                s1_last_reg;
    rbd_pkg::pixel_out_t res_reg;
    rbd_pkg::pixel_out_t res_next;
    logic                res_valid_reg;
    logic                accept;
    logic                advance;
    logic                lb_we;
    logic                lb_re;
    logic [rbd_pkg::TOT_W-1:0] tot_r;
    logic [rbd_pkg::TOT_W-1:0] tot_g;
    logic [rbd_pkg::TOT_W-1:0] tot_b;

    // output register moves when empty or taken; add stage moves into it
    assign advance   = !res_valid_reg || res_ready;
    assign pix_ready = !s1_valid_reg || advance;
    assign accept    = pix_valid && pix_ready;

    rbd_pos_ctrl u_pos
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .ctl       (ctl)
    );

    // horizontal pair sum of the held even-column pixel and this one
    always_comb
    begin
        pair_sum.red   = rbd_pkg::SUM_W'(first_reg.red_in)   + rbd_pkg::SUM_W'(pix.red_in);
        pair_sum.green = rbd_pkg::SUM_W'(first_reg.green_in) + rbd_pkg::SUM_W'(pix.green_in);
        pair_sum.blue  = rbd_pkg::SUM_W'(first_reg.blue_in)  + rbd_pkg::SUM_W'(pix.blue_in);
    end

    // even rows park their pair sums, odd rows fetch them back
    assign lb_we = accept && ctl.store_pair;
    assign lb_re = accept && ctl.emit;

    rbd_line_buf u_line
    (
        .clk   (clk),
        .we    (lb_we),
        .waddr (ctl.idx),
        .wdata (pair_sum),
        .re    (lb_re),
        .raddr (ctl.idx),
        .rdata (line_rd)
    );

    // first pixel of a pair, reset value zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
        end
        else if (accept && ctl.load_first)
        begin
            first_reg <= pix;
        end
    end

    // add stage: pair sum of the odd row waits beside the line buffer read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pix_ready)
        begin
            s1_valid_reg <= lb_re;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lb_re)
        begin
            s1_sum_reg  <= pair_sum;
            s1_last_reg <= ctl.last;
        end
    end

    // four-pixel sums, divide by 4 by dropping two bits
    always_comb
    begin
        tot_r = rbd_pkg::TOT_W'(s1_sum_reg.red)   + rbd_pkg::TOT_W'(line_rd.red);
        tot_g = rbd_pkg::TOT_W'(s1_sum_reg.green) + rbd_pkg::TOT_W'(line_rd.green);
        tot_b = rbd_pkg::TOT_W'(s1_sum_reg.blue)  + rbd_pkg::TOT_W'(line_rd.blue);
        res_next.red_out    = tot_r[rbd_pkg::TOT_W-1:2];
        res_next.green_out  = tot_g[rbd_pkg::TOT_W-1:2];
        res_next.blue_out   = tot_b[rbd_pkg::TOT_W-1:2];
        res_next.frame_last = s1_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // one pixel never both stores and fetches a pair
    a_lb_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(lb_we && lb_re))
        else $error("line buffer write and read in the same cycle");

    // a full add stage that cannot move keeps its contents
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_sum_reg)
                                        && $stable(s1_last_reg)))
        else $error("add stage lost its contents while stalled");

    // input stalls only when both stages are full and the result is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> (s1_valid_reg && res_valid_reg && !res_ready))
        else $error("input stalled without a full pipeline");

    // a result that was not taken is still offered unchanged
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |=> (res_valid_reg && $stable(res_reg)))
        else $error("result changed before transfer");

endmodule

`default_nettype wire
